FILE: src/pexp_pkg.sv
// Shared types and constants of the palette expander.
`timescale 1ns / 1ps

package pexp_pkg;

    // Request types carried by an input item.
    localparam logic REQ_PIXEL   = 1'b0;
    localparam logic REQ_PALETTE = 1'b1;

    // Source pixel depth.
    localparam logic MODE_8BPP = 1'b0;
    localparam logic MODE_4BPP = 1'b1;

    // Configuration register indexes and port widths.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH  = 1'd1;

    // Field widths fixed by the item format.
    localparam int BYTE_W  = 8;
    localparam int COLOR_W = 24;
    localparam int WORD_W  = 32;

    // One expanded pixel on its way to the result channel.
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
        logic              eor;
    } pix_t;

endpackage

FILE: src/pexp_ram.sv
// Generic simple dual-port RAM with a registered, read-first read port.
`timescale 1ns / 1ps

module pexp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // A read of the entry written in the same cycle returns the old contents.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/pexp_outq.sv
// Two-entry output queue that decouples the palette read from the receiver.
`timescale 1ns / 1ps

module pexp_outq
    import pexp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  pix_t       push_data,
    input  logic       pop,
    output logic       head_valid,
    output pix_t       head_data,
    output logic [1:0] count
);

    pix_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    // Pointer and fill count update; the issue credit keeps pushes off a full queue.
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Payload storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head_valid = (cnt_reg != 2'd0);
    assign head_data  = q_reg[rd_ptr_reg];
    assign count      = cnt_reg;

endmodule

FILE: src/palette_expand_to_rgba.sv
// Top level of the indexed-colour to 32-bit BGRA palette expander.
//
// Input channel (s_*): each item is either a palette write (s_req_type high),
// which stores colour and alpha in one slot and gives no result, or a pixel
// byte, which gives one result in 8bpp mode and two in 4bpp mode (high nybble
// first; only the high nybble on the last byte of an odd-width row).
// Result channel (m_*): one item per pixel, with last_of_run on the final pixel
// of a byte and end_of_row on the pixel that closes a row.
// Configuration: cfg_wr_en writes cfg_wr_data into register cfg_index
// (0 pixel mode, 1 row width); the user must write it only while the block is
// idle; the block itself does not enforce this. A pixel byte is registered in
// the front stage, its lookup in the read stage and the result in the output
// queue before it reaches m_valid. Throughput: while the queue has room, one
// palette lookup per cycle on a single RAM read port, so one byte per cycle in
// 8bpp mode and up to two lookups per byte in 4bpp mode. When the receiver
// stalls, a two-entry output queue absorbs the lookups in flight and the input
// stalls once the queue has no room. Reset clears the channels, column counter
// and sets 8bpp, row width 1; palette contents are undefined until written.
`timescale 1ns / 1ps

module palette_expand_to_rgba
    import pexp_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256,
    parameter int MAX_ROW_WIDTH   = 4096
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    // Input channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_req_type,
    input  logic [BYTE_W-1:0]     s_pixel_byte,
    input  logic [BYTE_W-1:0]     s_entry_index,
    input  logic [COLOR_W-1:0]    s_entry_color,
    input  logic [BYTE_W-1:0]     s_entry_alpha,
    // Result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [WORD_W-1:0]     m_rgba_word,
    output logic                  m_last_of_run,
    output logic                  m_end_of_row
);

    localparam int AW    = $clog2(PALETTE_ENTRIES);
    localparam int CW    = $clog2(MAX_ROW_WIDTH);
    localparam int CMP_W = (CW + 1 > CFG_DATA_W) ? CW + 1 : CFG_DATA_W;
    localparam logic [CMP_W-1:0]  MAX_W     = CMP_W'(MAX_ROW_WIDTH);
    localparam logic [BYTE_W:0]   NUM_SLOTS = (BYTE_W + 1)'(PALETTE_ENTRIES);

    // Configuration registers.
    logic                  mode_reg;
    logic [CFG_DATA_W-1:0] row_width_reg;

    // Front stage: the pixel byte whose lookups are being issued.
    logic              front_valid_reg, front_valid_next;
    logic [BYTE_W-1:0] front_byte_reg;
    logic              phase_reg, phase_next;
    logic [CW-1:0]     col_reg, col_next;

    // Read stage: a lookup whose RAM data arrives in this cycle.
    logic rd_valid_reg, rd_zero_reg, rd_last_reg, rd_eor_reg;

    logic              accept, issue, credit_ok, front_done, pop;
    logic              hit, iss_last, iss_zero;
    logic [BYTE_W-1:0] iss_index;
    logic [CMP_W-1:0]  w_min1, w_eff, col_plus;
    logic [2:0]        occ;
    logic [1:0]        q_count;
    logic              ram_we;
    logic [WORD_W-1:0] ram_rdata;
    pix_t              push_data, head_data;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_8BPP;
            row_width_reg <= CFG_DATA_W'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_PIXEL_MODE: mode_reg      <= cfg_wr_data[0];
                CFG_ROW_WIDTH:  row_width_reg <= cfg_wr_data;
                default:        ;
            endcase
        end
    end

    // Effective row width: zero counts as one, large values saturate.
    always_comb begin
        w_min1   = (row_width_reg == '0) ? CMP_W'(1) : CMP_W'(row_width_reg);
        w_eff    = (w_min1 > MAX_W) ? MAX_W : w_min1;
        col_plus = CMP_W'(col_reg) + CMP_W'(1);
        hit      = (col_plus >= w_eff);
    end

    // Issue credit: never have more lookups in flight than the queue can hold.
    assign pop       = m_valid && m_ready;
    assign occ       = 3'(q_count) + 3'(rd_valid_reg);
    assign credit_ok = pop ? (occ <= 3'd2) : (occ <= 3'd1);
    assign issue     = front_valid_reg && credit_ok;

    // The byte is finished after its last lookup: 8bpp, low nybble, or a row end.
    assign front_done = issue && (mode_reg == MODE_8BPP || phase_reg || hit);
    assign s_ready    = !front_valid_reg || front_done;
    assign accept     = s_valid && s_ready;

    // Index of the current lookup and whether it falls outside the palette.
    always_comb begin
        if (mode_reg == MODE_8BPP) begin
            iss_index = front_byte_reg;
        end else if (phase_reg) begin
            iss_index = {4'd0, front_byte_reg[3:0]};
        end else begin
            iss_index = {4'd0, front_byte_reg[7:4]};
        end
        iss_zero = ({1'b0, iss_index} >= NUM_SLOTS);
        iss_last = (mode_reg == MODE_8BPP) || phase_reg || hit;
    end

    // Front stage and column counter update.
    always_comb begin
        front_valid_next = front_valid_reg;
        phase_next       = phase_reg;
        col_next         = col_reg;
        if (issue) begin
            col_next   = hit ? '0 : col_plus[CW-1:0];
            phase_next = 1'b1;
        end
        if (front_done) begin
            front_valid_next = 1'b0;
        end
        if (accept && s_req_type == REQ_PIXEL) begin
            front_valid_next = 1'b1;
            phase_next       = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
            phase_reg       <= 1'b0;
            col_reg         <= '0;
            rd_valid_reg    <= 1'b0;
        end else begin
            front_valid_reg <= front_valid_next;
            phase_reg       <= phase_next;
            col_reg         <= col_next;
            rd_valid_reg    <= issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_req_type == REQ_PIXEL) begin
            front_byte_reg <= s_pixel_byte;
        end
        if (issue) begin
            rd_zero_reg <= iss_zero;
            rd_last_reg <= iss_last;
            rd_eor_reg  <= hit;
        end
    end

    // Palette writes go straight to the RAM; a pixel byte accepted later is
    // held in the front stage before its read, so no forwarding is needed.
    assign ram_we = accept && s_req_type == REQ_PALETTE
                    && ({1'b0, s_entry_index} < NUM_SLOTS);

    pexp_ram #(
        .WIDTH (WORD_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (s_entry_index[AW-1:0]),
        .wdata ({s_entry_alpha, s_entry_color}),
        .re    (issue),
        .raddr (iss_index[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Lookup results enter the output queue.
    always_comb begin
        push_data.word = rd_zero_reg ? '0 : ram_rdata;
        push_data.last = rd_last_reg;
        push_data.eor  = rd_eor_reg;
    end

    pexp_outq u_outq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (rd_valid_reg),
        .push_data  (push_data),
        .pop        (pop),
        .head_valid (m_valid),
        .head_data  (head_data),
        .count      (q_count)
    );

    assign m_rgba_word   = head_data.word;
    assign m_last_of_run = head_data.last;
    assign m_end_of_row  = head_data.eor;

endmodule

FILE: src/pexp_checker.sv
// Port-level checks of the palette expander, bound to the top level.
`timescale 1ns / 1ps

module pexp_checker
    import pexp_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input logic [WORD_W-1:0] m_rgba_word,
    input logic              m_last_of_run,
    input logic              m_end_of_row
);

    // A stalled result item holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_rgba_word)
            && $stable(m_last_of_run) && $stable(m_end_of_row))
        else $error("stalled result item changed");

    // A pixel that closes a row is always the last pixel of its byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_end_of_row |-> m_last_of_run)
        else $error("end of row on a pixel that is not last of its byte");

    // The second pixel of a 4bpp byte follows its first without a gap.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_of_run |=> m_valid)
        else $error("gap inside a two-pixel run");

    // Reset empties the result channel.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind palette_expand_to_rgba pexp_checker u_checker (.*);
